### hw/rtl/pcsm_pkg.sv
package pcsm_pkg;

  localparam int unsigned ID_W     = 32;
  localparam int unsigned SLOT_F_W = 4;

  // Request type codes.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Placement request from the request stage to the allocator.
  typedef struct packed {
    logic            place;
    logic [ID_W-1:0] id;
  } alloc_req_t;

endpackage

### hw/rtl/pcsm_if.sv
interface pcsm_req_if import pcsm_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [ID_W-1:0] page_id;

  modport source (output valid, output req_type, output page_id, input ready);
  modport sink   (input valid, input req_type, input page_id, output ready);
endinterface

interface pcsm_rsp_if import pcsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                hit;
  logic [SLOT_F_W-1:0] slot;
  logic                fetch_needed;
  logic                evicted;
  logic [ID_W-1:0]     evicted_id;

  modport source (output valid, output hit, output slot, output fetch_needed,
                  output evicted, output evicted_id, input ready);
  modport sink   (input valid, input hit, input slot, input fetch_needed,
                  input evicted, input evicted_id, output ready);
endinterface

### hw/rtl/pcsm_tag_array.sv
module pcsm_tag_array import pcsm_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned SW    = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] lookup_id,
  output logic            hit,
  output logic [SW-1:0]   hit_slot,
  input  logic            wr_en,
  input  logic [SW-1:0]   wr_slot,
  input  logic [ID_W-1:0] wr_id
);

  logic [ID_W-1:0]  tag_r [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] match;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      if (wr_en && (wr_slot == SW'(i))) begin
        tag_r[i] <= wr_id;
      end
    end
  end

  // Tags are unique, but the lowest matching slot wins should two ever match.
  always_comb begin
    hit_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      match[i] = valid_r[i] && (tag_r[i] == lookup_id);
      if (match[i]) begin
        hit_slot = SW'(i);
      end
    end
    hit = |match;
  end

endmodule

### hw/rtl/pcsm_alloc.sv
module pcsm_alloc import pcsm_pkg::*; #(
  parameter int unsigned SLOTS = 16,
  parameter int unsigned SW    = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  alloc_req_t      req,
  output logic [SW-1:0]   slot,
  output logic            evict,
  output logic [ID_W-1:0] evict_id,
  output logic            free_empty
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  // Slots are never returned to the free stack, so its top entry always equals
  // free count minus one. The used stack is only ever read at its top, which is
  // the slot pushed last; that slot and its tag are kept directly.
  logic [CW-1:0]   free_cnt_r, free_cnt_nxt;
  logic [SW-1:0]   used_top_r;
  logic [ID_W-1:0] victim_tag_r;
  logic [CW-1:0]   free_top;

  assign free_empty = (free_cnt_r == '0);
  assign free_top   = free_cnt_r - CW'(1);

  always_comb begin
    free_cnt_nxt = free_cnt_r;
    if (free_empty) begin
      slot  = used_top_r;
      evict = 1'b1;
    end else begin
      slot  = free_top[SW-1:0];
      evict = 1'b0;
      if (req.place) begin
        free_cnt_nxt = free_top;
      end
    end
    evict_id = evict ? victim_tag_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= CW'(SLOTS);
    end else begin
      free_cnt_r <= free_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.place) begin
      used_top_r   <= slot;
      victim_tag_r <= req.id;
    end
  end

endmodule

### hw/rtl/page_cache_slot_manager_unit.sv
// Channel | Dir | Beat payload                                  | Handshake
// in_req  | in  | req_type, page_id                             | valid/ready
// out_rsp | out | hit, slot, fetch_needed, evicted, evicted_id   | valid/ready
//
// One request per cycle while the output is not stalled; a request passes
// through the request register, then the result register, to the result beat.
// The tag compare over all slots and the allocator update sit between them.
// Synchronous active-low reset empties the cache; no clearing pass is needed.
// A stalled output holds its beat, and the request register keeps accepting
// until both stages are full.
module page_cache_slot_manager_unit import pcsm_pkg::*; #(
  parameter int unsigned SLOTS = 16
) (
  input logic        clk,
  input logic        rst_n,
  pcsm_req_if.sink   in_req,
  pcsm_rsp_if.source out_rsp
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic            s1_v_r;
  logic            s1_type_r;
  logic [ID_W-1:0] s1_id_r;
  logic            out_v_r;
  logic            advance;
  logic            in_rdy;

  logic            hit_w;
  logic [SW-1:0]   hit_slot_w;
  alloc_req_t      areq;
  logic [SW-1:0]   alloc_slot_w;
  logic            evict_w;
  logic [ID_W-1:0] evict_id_w;
  logic            free_empty_w;
  logic [SW-1:0]   slot_w;
  logic [SW+SLOT_F_W-1:0] slot_ext;

  assign advance = s1_v_r && (!out_v_r || out_rsp.ready);
  assign in_rdy  = !s1_v_r || advance;
  assign in_req.ready = in_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_rdy) begin
      s1_v_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_req.valid) begin
      s1_type_r <= in_req.req_type;
      s1_id_r   <= in_req.page_id;
    end
  end

  assign areq.place = advance && !hit_w;
  assign areq.id    = s1_id_r;

  pcsm_tag_array #(.SLOTS(SLOTS), .SW(SW)) u_tags (
    .clk       (clk),
    .rst_n     (rst_n),
    .lookup_id (s1_id_r),
    .hit       (hit_w),
    .hit_slot  (hit_slot_w),
    .wr_en     (areq.place),
    .wr_slot   (alloc_slot_w),
    .wr_id     (s1_id_r)
  );

  pcsm_alloc #(.SLOTS(SLOTS), .SW(SW)) u_alloc (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (areq),
    .slot       (alloc_slot_w),
    .evict      (evict_w),
    .evict_id   (evict_id_w),
    .free_empty (free_empty_w)
  );

  assign slot_w   = hit_w ? hit_slot_w : alloc_slot_w;
  assign slot_ext = {{SLOT_F_W{1'b0}}, slot_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp.hit          <= hit_w;
      out_rsp.slot         <= slot_ext[SLOT_F_W-1:0];
      out_rsp.fetch_needed <= !hit_w && (s1_type_r == REQ_READ);
      out_rsp.evicted      <= !hit_w && evict_w;
      out_rsp.evicted_id   <= hit_w ? '0 : evict_id_w;
    end
  end

  assign out_rsp.valid = out_v_r;

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_rsp.hit) |-> (!out_rsp.fetch_needed && !out_rsp.evicted))
    else $error("hit beat reports a fetch or an eviction");

  a_evict_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_rsp.evicted) |-> (out_rsp.evicted_id == '0))
    else $error("evicted_id nonzero without an eviction");

  a_evict_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !hit_w) |=> (out_rsp.evicted == $past(free_empty_w)))
    else $error("eviction does not follow an empty free stack");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rdy |-> s1_v_r)
    else $error("request stage stalls while empty");

endmodule
